### design/itaf_pkg.sv
// Shared types, constants and the glyph function of the integer-to-ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none

package itaf_pkg;

  // Decimal digit capacity of the BCD register; 20 digits cover any 64-bit value.
  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned BCD_BITS   = BCD_DIGITS * 4;
  localparam int unsigned HEX_BITS   = 64;
  localparam int unsigned IN_BITS    = 72;
  localparam int unsigned OUT_BITS   = 8;

  localparam logic       CMD_HEX     = 1'b0;
  localparam logic       CMD_DEC     = 1'b1;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_NINE  = 7'h39;
  localparam logic [6:0] ASCII_UPA   = 7'h41;
  localparam logic [6:0] ASCII_UPF   = 7'h46;
  localparam logic [6:0] ASCII_X     = 7'h78;

  localparam logic [1:0] HW_TWO      = 2'd0;
  localparam logic [1:0] HW_FOUR     = 2'd1;
  localparam logic [1:0] HW_EIGHT    = 2'd2;
  localparam logic [1:0] HW_SIXTEEN  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREFIX0,
    ST_PREFIX1,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_X,
    SEL_DIGIT
  } char_sel_e;

  typedef struct packed {
    logic      load_hex;
    logic      load_dec;
    logic      dab_step;
    logic      load_dec_cnt;
    logic      shift_out;
    char_sel_e char_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic cnt_one;
  } dp_status_t;

  // Maps one nibble to its upper-case hex or decimal glyph.
  function automatic logic [6:0] glyph(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = ASCII_ZERO + {3'b000, nib};
    end else begin
      c = ASCII_UPA + {3'b000, nib - 4'd10};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/itaf_datapath.sv
// Datapath: double-dabble BCD converter, nibble shift register, counter and character mux.
`timescale 1ns / 1ps
`default_nettype none

module itaf_datapath #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned CNT_W      = 7
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire itaf_pkg::dp_cmd_t cmd_i,
  input  wire  [1:0]             hex_width_i,
  input  wire  [63:0]            value_i,
  output itaf_pkg::dp_status_t   status_o,
  output logic [6:0]             char_o
);
  import itaf_pkg::*;

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_BITS-1:0]   bcd_q, bcd_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic [BCD_BITS-1:0]   bcd_adj;
  logic [HEX_BITS-1:0]   hex_val;
  logic [HEX_BITS-1:0]   hex_aligned;
  logic [CNT_W-1:0]      hex_cnt;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // Hex digits are left-aligned so the first one printed sits in the top nibble.
  always_comb begin
    hex_val                   = '0;
    hex_val[VALUE_BITS-1:0]   = value_i[VALUE_BITS-1:0];
    case (hex_width_i)
      HW_TWO: begin
        hex_aligned = hex_val << 56;
        hex_cnt     = CNT_W'(2);
      end
      HW_FOUR: begin
        hex_aligned = hex_val << 48;
        hex_cnt     = CNT_W'(4);
      end
      HW_EIGHT: begin
        hex_aligned = hex_val << 32;
        hex_cnt     = CNT_W'(8);
      end
      default: begin
        hex_aligned = hex_val;
        hex_cnt     = CNT_W'(16);
      end
    endcase
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (cmd_i.load_hex) begin
      bcd_d = {hex_aligned, {(BCD_BITS - HEX_BITS){1'b0}}};
      cnt_d = hex_cnt;
    end else if (cmd_i.load_dec) begin
      bin_d = value_i[VALUE_BITS-1:0];
      bcd_d = '0;
      cnt_d = CNT_W'(VALUE_BITS);
    end else if (cmd_i.dab_step) begin
      bcd_d = {bcd_adj[BCD_BITS-2:0], bin_q[VALUE_BITS-1]};
      bin_d = bin_q << 1;
      cnt_d = cmd_i.load_dec_cnt ? CNT_W'(BCD_DIGITS) : cnt_q - CNT_W'(1);
    end else if (cmd_i.shift_out) begin
      bcd_d = bcd_q << 4;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign status_o = '{top_zero: (bcd_q[BCD_BITS-1 -: 4] == 4'd0),
                      cnt_one:  (cnt_q == CNT_W'(1))};

  always_comb begin
    case (cmd_i.char_sel)
      SEL_ZERO: char_o = ASCII_ZERO;
      SEL_X:    char_o = ASCII_X;
      default:  char_o = glyph(bcd_q[BCD_BITS-1 -: 4]);
    endcase
  end

endmodule

`default_nettype wire

### design/itaf_controller.sv
// Controller: state machine sequencing load, conversion, leading-zero skip and output.
`timescale 1ns / 1ps
`default_nettype none

module itaf_controller (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  input  wire                       in_cmd_i,
  input  wire                       out_ready_i,
  input  wire itaf_pkg::dp_status_t status_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output logic                      out_last_o,
  output itaf_pkg::dp_cmd_t         cmd_o
);
  import itaf_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_cmd_i == CMD_HEX) ? ST_PREFIX0 : ST_CONVERT;
        end
      end
      ST_PREFIX0: begin
        if (out_ready_i) state_d = ST_PREFIX1;
      end
      ST_PREFIX1: begin
        if (out_ready_i) state_d = ST_EMIT;
      end
      ST_CONVERT: begin
        if (status_i.cnt_one) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!status_i.top_zero || status_i.cnt_one) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i && status_i.cnt_one) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = 1'b0;
    out_valid_o        = 1'b0;
    out_last_o         = 1'b0;
    cmd_o              = '0;
    cmd_o.char_sel     = SEL_DIGIT;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_hex = in_valid_i && (in_cmd_i == CMD_HEX);
        cmd_o.load_dec = in_valid_i && (in_cmd_i == CMD_DEC);
      end
      ST_PREFIX0: begin
        out_valid_o    = 1'b1;
        cmd_o.char_sel = SEL_ZERO;
      end
      ST_PREFIX1: begin
        out_valid_o    = 1'b1;
        cmd_o.char_sel = SEL_X;
      end
      ST_CONVERT: begin
        cmd_o.dab_step     = 1'b1;
        cmd_o.load_dec_cnt = status_i.cnt_one;
      end
      ST_SKIP: begin
        // Leading zero digits are dropped, but the final digit always stays.
        cmd_o.shift_out = status_i.top_zero && !status_i.cnt_one;
      end
      ST_EMIT: begin
        out_valid_o     = 1'b1;
        out_last_o      = status_i.cnt_one;
        cmd_o.shift_out = out_ready_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### design/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: controller, datapath and stream ports.
// Hex mode: the "0" of the prefix appears in the cycle after the input transfer, then one
// character per cycle while m_axis_tready_i is high; an item is 2 + digits characters (4 to 18).
// Decimal mode: the double-dabble conversion, one step per value bit, and then the leading-zero
// skip precede the first digit.
// Reset (rst_ni low, asynchronous) returns the controller to idle with no output pending.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  wire [71:0] s_axis_tdata_i,  // cmd[0], hex_width[2:1], value[66:3], zero pad
  output logic       m_axis_tvalid_o,
  input  wire        m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // char_out[6:0], zero pad[7]
  output logic       m_axis_tlast_o   // last
);
  import itaf_pkg::*;

  localparam int unsigned CNT_MAX = (VALUE_BITS > BCD_DIGITS) ? VALUE_BITS : BCD_DIGITS;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic [6:0] char_out;

  itaf_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_cmd_i    (s_axis_tdata_i[0]),
    .out_ready_i (m_axis_tready_i),
    .status_i    (dp_status),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_last_o  (m_axis_tlast_o),
    .cmd_o       (dp_cmd)
  );

  itaf_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .hex_width_i (s_axis_tdata_i[2:1]),
    .value_i     (s_axis_tdata_i[66:3]),
    .status_o    (dp_status),
    .char_o      (char_out)
  );

  assign m_axis_tdata_o = {1'b0, char_out};

  // The block never takes a new number while a character is offered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while output valid");

  // Every offered character is a decimal digit, an upper-case hex digit or 'x'.
  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((char_out >= ASCII_ZERO && char_out <= ASCII_NINE) ||
       (char_out >= ASCII_UPA && char_out <= ASCII_UPF) ||
       (char_out == ASCII_X)))
    else $error("illegal character on output");

  // A hex transfer is followed at once by the '0' of the prefix.
  a_hex_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[0] == CMD_HEX) |=>
      (m_axis_tvalid_o && char_out == ASCII_ZERO && !m_axis_tlast_o))
    else $error("hex prefix missing");

endmodule

`default_nettype wire
